// ===== hdl/pgt_pkg.sv =====
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared types, constants and the microcode store of the pulse gap
// tachometer.
// ----------------------------------------------------------------------------
`default_nettype none

package pgt_pkg;

   // fixed payload widths
   localparam int OP_W        = 2;
   localparam int TIME_W      = 32;
   localparam int SPEED_W     = 16;
   localparam int TIMEOUT_W   = 31;
   localparam int MIN_GAP_W   = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // speed arithmetic
   localparam int unsigned IDLE_FILL    = 60000;
   localparam int unsigned SPEED_NUM_Q8 = 3840000;   // 15000 scaled by 2^8 for Q8.8 speeds
   localparam int unsigned FILL_W       = 16;        // gaps below the filler fit here

   // defaults
   localparam int DEFAULT_WINDOW_DEPTH = 3;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(15000);
   localparam logic [MIN_GAP_W-1:0] MIN_GAP_RESET = MIN_GAP_W'(200);

   // operation codes
   localparam logic [OP_W-1:0] OP_EDGE    = 2'd0;
   localparam logic [OP_W-1:0] OP_AVERAGE = 2'd1;
   localparam logic [OP_W-1:0] OP_LATEST  = 2'd2;

   // register select (paddr bit 2)
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_MIN_GAP = 1'b1;

   // microcode
   localparam int PC_W = 4;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_FILL_INIT,
      ACT_FILL_PUSH,
      ACT_SET_START,
      ACT_SCAN_INIT,
      ACT_SCAN_ADD,
      ACT_AVG_SETUP,
      ACT_LATEST_SETUP,
      ACT_DIV_STEP,
      ACT_SATURATE,
      ACT_EDGE,
      ACT_EMIT
   } act_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_BEAT,
      COND_OP_EDGE,
      COND_OP_UNUSED,
      COND_NO_IDLE,
      COND_FILL_MORE,
      COND_OP_LATEST,
      COND_SCAN_MORE,
      COND_SUM_ZERO,
      COND_LATEST_BAD,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   // status flags from the datapath, tested by the jump conditions
   typedef struct packed {
      logic no_beat;
      logic op_edge;
      logic op_unused;
      logic no_idle;
      logic fill_more;
      logic op_latest;
      logic scan_more;
      logic sum_zero;
      logic latest_bad;
      logic div_more;
      logic out_busy;
   } flags_type;

   // program store: act, jump condition, jump target (else fall through)
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] addr);
      ctrl_word_type w;
      case (addr)
         4'd0:    w = '{ACT_LOAD,         COND_NO_BEAT,    4'd0};
         4'd1:    w = '{ACT_NOP,          COND_OP_EDGE,    4'd14};
         4'd2:    w = '{ACT_NOP,          COND_OP_UNUSED,  4'd15};
         4'd3:    w = '{ACT_FILL_INIT,    COND_NO_IDLE,    4'd6};
         4'd4:    w = '{ACT_FILL_PUSH,    COND_NEVER,      4'd0};
         4'd5:    w = '{ACT_SET_START,    COND_FILL_MORE,  4'd4};
         4'd6:    w = '{ACT_SCAN_INIT,    COND_OP_LATEST,  4'd10};
         4'd7:    w = '{ACT_SCAN_ADD,     COND_SCAN_MORE,  4'd7};
         4'd8:    w = '{ACT_AVG_SETUP,    COND_SUM_ZERO,   4'd15};
         4'd9:    w = '{ACT_NOP,          COND_ALWAYS,     4'd11};
         4'd10:   w = '{ACT_LATEST_SETUP, COND_LATEST_BAD, 4'd15};
         4'd11:   w = '{ACT_DIV_STEP,     COND_DIV_MORE,   4'd11};
         4'd12:   w = '{ACT_SATURATE,     COND_ALWAYS,     4'd15};
         4'd13:   w = '{ACT_NOP,          COND_ALWAYS,     4'd0};
         4'd14:   w = '{ACT_EDGE,         COND_NEVER,      4'd0};
         4'd15:   w = '{ACT_EMIT,         COND_OUT_BUSY,   4'd15};
         default: w = '{ACT_NOP,          COND_ALWAYS,     4'd0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pgt_if.sv =====
// ----------------------------------------------------------------------------
// pgt_req_if / pgt_rsp_if
// Valid/ready channels for the tachometer: request beats in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgt_req_if;
   logic                        valid;
   logic                        ready;
   logic [pgt_pkg::OP_W-1:0]    operation;
   logic [pgt_pkg::TIME_W-1:0]  now_ms;

   modport source (output valid, output operation, output now_ms, input ready);
   modport sink   (input valid, input operation, input now_ms, output ready);
endinterface

interface pgt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pgt_pkg::SPEED_W-1:0] speed_q8;
   logic                        pulse_recorded;

   modport source (output valid, output speed_q8, output pulse_recorded, input ready);
   modport sink   (input valid, input speed_q8, input pulse_recorded, output ready);
endinterface

`default_nettype wire

// ===== hdl/pgt_sequencer.sv =====
// ----------------------------------------------------------------------------
// pgt_sequencer
// Step counter over the microcode store; picks the next step from the
// addressed control word and the datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pgt_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pgt_pkg::flags_type      flags,
   output pgt_pkg::ctrl_word_type       ctrl
);

   logic [pgt_pkg::PC_W-1:0] pc_ff;
   logic [pgt_pkg::PC_W-1:0] pc_in;
   logic                     take_jump;

   assign ctrl = pgt_pkg::ucode_rom(pc_ff);

   // jump condition select
   always_comb begin
      case (ctrl.cond)
         pgt_pkg::COND_NEVER:      take_jump = 1'b0;
         pgt_pkg::COND_ALWAYS:     take_jump = 1'b1;
         pgt_pkg::COND_NO_BEAT:    take_jump = flags.no_beat;
         pgt_pkg::COND_OP_EDGE:    take_jump = flags.op_edge;
         pgt_pkg::COND_OP_UNUSED:  take_jump = flags.op_unused;
         pgt_pkg::COND_NO_IDLE:    take_jump = flags.no_idle;
         pgt_pkg::COND_FILL_MORE:  take_jump = flags.fill_more;
         pgt_pkg::COND_OP_LATEST:  take_jump = flags.op_latest;
         pgt_pkg::COND_SCAN_MORE:  take_jump = flags.scan_more;
         pgt_pkg::COND_SUM_ZERO:   take_jump = flags.sum_zero;
         pgt_pkg::COND_LATEST_BAD: take_jump = flags.latest_bad;
         pgt_pkg::COND_DIV_MORE:   take_jump = flags.div_more;
         pgt_pkg::COND_OUT_BUSY:   take_jump = flags.out_busy;
         default:                  take_jump = 1'b0;
      endcase
   end

   // fall through wraps from the last step back to fetch
   assign pc_in = take_jump ? ctrl.target : pc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pulse_gap_tachometer.sv =====
// An edge beat passes decode and the edge step to emit; an unused operation
// goes from decode to emit. Queries push at most WINDOW_DEPTH idle fillers,
// an average query scans the window, and a usable divisor (a nonzero sum or a
// valid latest gap) drives a restoring divider over the N dividend bits (24
// at depth 3), one bit per cycle. One beat in flight; the next is taken once
// the result is in the output register. Synchronous reset restores state.
// ----------------------------------------------------------------------------
// pulse_gap_tachometer
// Tachometer on time-stamped sensor edges with a moving window of gaps;
// answers average and latest speed in Q8.8 under microcode control.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_gap_tachometer #(
   parameter int WINDOW_DEPTH = pgt_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pgt_req_if.sink                                req,
   pgt_rsp_if.source                              rsp,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pgt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [pgt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [pgt_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   localparam int SUM_W     = $clog2(WINDOW_DEPTH * (pgt_pkg::IDLE_FILL - 1) + 1);
   localparam int NUM_W     = $clog2(WINDOW_DEPTH * pgt_pkg::SPEED_NUM_Q8 + 1);
   localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int TW        = pgt_pkg::TIME_W;
   localparam int SW        = pgt_pkg::SPEED_W;

   // configuration registers
   logic [pgt_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [pgt_pkg::MIN_GAP_W-1:0] min_gap_ff;

   // tachometer state
   logic [TW-1:0]        start_ff,   start_in;
   logic [TW-1:0]        latest_ff,  latest_in;
   logic [TW-1:0]        window_ff [WINDOW_DEPTH];
   logic [TW-1:0]        window_in [WINDOW_DEPTH];

   // working registers
   logic [pgt_pkg::OP_W-1:0] op_ff,    op_in;
   logic [TW-1:0]            now_ff,   now_in;
   logic signed [TW-1:0]     gap_ff,   gap_in;
   logic [TW-1:0]            rem_t_ff, rem_t_in;   // idle fill remainder
   logic [CNT_W-1:0]         fcnt_ff,  fcnt_in;
   logic [CNT_W-1:0]         scnt_ff,  scnt_in;
   logic [SUM_W-1:0]         sum_ff,   sum_in;
   logic [NUM_W-1:0]         num_ff,   num_in;
   logic [NUM_W-1:0]         dvd_ff,   dvd_in;     // dividend out, quotient in
   logic [SUM_W-1:0]         den_ff,   den_in;
   logic [SUM_W-1:0]         rem_d_ff, rem_d_in;
   logic [DIV_CNT_W-1:0]     dcnt_ff,  dcnt_in;
   logic [SW-1:0]            speed_ff, speed_in;
   logic                     rec_ff,   rec_in;

   // output register
   logic                     rsp_valid_ff;
   logic [SW-1:0]            rsp_speed_ff;
   logic                     rsp_rec_ff;

   pgt_pkg::ctrl_word_type   ctrl;
   pgt_pkg::flags_type       flags;

   logic                     over_timeout;
   logic                     over_min;
   logic                     out_busy;
   logic                     emit_fire;
   logic                     csr_write;
   logic [SUM_W:0]           rem_shift;
   logic                     div_ge;

   pgt_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // gap comparisons (signed gap against unsigned limits)
   assign over_timeout = gap_ff > $signed({1'b0, timeout_ff});
   assign over_min     = gap_ff > $signed({{(TW - pgt_pkg::MIN_GAP_W){1'b0}}, min_gap_ff});

   assign out_busy  = rsp_valid_ff && !rsp.ready;
   assign emit_fire = (ctrl.act == pgt_pkg::ACT_EMIT) && !out_busy;

   // one restoring divider step
   assign rem_shift = {rem_d_ff, dvd_ff[NUM_W-1]};
   assign div_ge    = rem_shift >= {1'b0, den_ff};

   // flags for the jump conditions
   always_comb begin
      flags.no_beat    = !req.valid;
      flags.op_edge    = op_ff == pgt_pkg::OP_EDGE;
      flags.op_unused  = (op_ff != pgt_pkg::OP_AVERAGE) && (op_ff != pgt_pkg::OP_LATEST);
      flags.no_idle    = !over_timeout;
      flags.fill_more  = (fcnt_ff < CNT_W'(WINDOW_DEPTH)) &&
                         (rem_t_ff >= {1'b0, timeout_ff});
      flags.op_latest  = op_ff == pgt_pkg::OP_LATEST;
      flags.scan_more  = scnt_ff != CNT_W'(WINDOW_DEPTH - 1);
      flags.sum_zero   = sum_ff == '0;
      flags.latest_bad = (latest_ff == '0) || (latest_ff >= TW'(pgt_pkg::IDLE_FILL));
      flags.div_more   = dcnt_ff != DIV_CNT_W'(NUM_W - 1);
      flags.out_busy   = out_busy;
   end

   // datapath next values, selected by the control word
   always_comb begin
      op_in    = op_ff;
      now_in   = now_ff;
      gap_in   = gap_ff;
      start_in = start_ff;
      latest_in = latest_ff;
      window_in = window_ff;
      rem_t_in = rem_t_ff;
      fcnt_in  = fcnt_ff;
      scnt_in  = scnt_ff;
      sum_in   = sum_ff;
      num_in   = num_ff;
      dvd_in   = dvd_ff;
      den_in   = den_ff;
      rem_d_in = rem_d_ff;
      dcnt_in  = dcnt_ff;
      speed_in = speed_ff;
      rec_in   = rec_ff;

      case (ctrl.act)
         pgt_pkg::ACT_LOAD: begin
            if (req.valid) begin
               op_in    = req.operation;
               now_in   = req.now_ms;
               gap_in   = $signed(req.now_ms - start_ff);
               speed_in = '0;
               rec_in   = 1'b0;
            end
         end
         pgt_pkg::ACT_FILL_INIT: begin
            rem_t_in = gap_ff;
            fcnt_in  = '0;
         end
         pgt_pkg::ACT_FILL_PUSH: begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[WINDOW_DEPTH-1] = TW'(pgt_pkg::IDLE_FILL);
            rem_t_in = rem_t_ff - {1'b0, timeout_ff};
            fcnt_in  = fcnt_ff + 1'b1;
         end
         pgt_pkg::ACT_SET_START: begin
            start_in = now_ff;
         end
         pgt_pkg::ACT_SCAN_INIT: begin
            scnt_in = '0;
            sum_in  = '0;
            num_in  = '0;
         end
         pgt_pkg::ACT_SCAN_ADD: begin
            // rotate the window once round; order is restored after a full pass
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[WINDOW_DEPTH-1] = window_ff[0];
            if (window_ff[0] < TW'(pgt_pkg::IDLE_FILL)) begin
               sum_in = sum_ff + SUM_W'(window_ff[0][pgt_pkg::FILL_W-1:0]);
               num_in = num_ff + NUM_W'(pgt_pkg::SPEED_NUM_Q8);
            end
            scnt_in = scnt_ff + 1'b1;
         end
         pgt_pkg::ACT_AVG_SETUP: begin
            dvd_in   = num_ff;
            den_in   = sum_ff;
            rem_d_in = '0;
            dcnt_in  = '0;
         end
         pgt_pkg::ACT_LATEST_SETUP: begin
            dvd_in   = NUM_W'(pgt_pkg::SPEED_NUM_Q8);
            den_in   = SUM_W'(latest_ff[pgt_pkg::FILL_W-1:0]);
            rem_d_in = '0;
            dcnt_in  = '0;
         end
         pgt_pkg::ACT_DIV_STEP: begin
            rem_d_in = div_ge ? SUM_W'(rem_shift - {1'b0, den_ff}) : rem_shift[SUM_W-1:0];
            dvd_in   = {dvd_ff[NUM_W-2:0], div_ge};
            dcnt_in  = dcnt_ff + 1'b1;
         end
         pgt_pkg::ACT_SATURATE: begin
            speed_in = (|dvd_ff[NUM_W-1:SW]) ? {SW{1'b1}} : dvd_ff[SW-1:0];
         end
         pgt_pkg::ACT_EDGE: begin
            if (gap_ff[TW-1] || over_timeout || over_min) begin
               start_in = now_ff;
            end
            if (over_min) begin
               latest_in = gap_ff;
               for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[WINDOW_DEPTH-1] = gap_ff;
               rec_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // tachometer state, reset to its initial values
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         latest_ff <= '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= TW'(pgt_pkg::IDLE_FILL);
         end
      end else begin
         start_ff  <= start_in;
         latest_ff <= latest_in;
         window_ff <= window_in;
      end
   end

   // working registers; counters cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= '0;
         scnt_ff <= '0;
         dcnt_ff <= '0;
         op_ff   <= pgt_pkg::OP_EDGE;
      end else begin
         fcnt_ff <= fcnt_in;
         scnt_ff <= scnt_in;
         dcnt_ff <= dcnt_in;
         op_ff   <= op_in;
      end
      now_ff   <= now_in;
      gap_ff   <= gap_in;
      rem_t_ff <= rem_t_in;
      sum_ff   <= sum_in;
      num_ff   <= num_in;
      dvd_ff   <= dvd_in;
      den_ff   <= den_in;
      rem_d_ff <= rem_d_in;
      speed_ff <= speed_in;
      rec_ff   <= rec_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_fire) begin
         rsp_speed_ff <= speed_ff;
         rsp_rec_ff   <= rec_ff;
      end
   end

   assign req.ready          = ctrl.act == pgt_pkg::ACT_LOAD;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.speed_q8       = rsp_speed_ff;
   assign rsp.pulse_recorded = rsp_rec_ff;

   // register port: write in the access phase, read mux on bit 2
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= pgt_pkg::TIMEOUT_RESET;
         min_gap_ff <= pgt_pkg::MIN_GAP_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            pgt_pkg::REG_TIMEOUT: timeout_ff <= pwdata[pgt_pkg::TIMEOUT_W-1:0];
            pgt_pkg::REG_MIN_GAP: min_gap_ff <= pwdata[pgt_pkg::MIN_GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         pgt_pkg::REG_TIMEOUT: prdata = {1'b0, timeout_ff};
         pgt_pkg::REG_MIN_GAP: prdata = {{(pgt_pkg::CSR_DATA_W - pgt_pkg::MIN_GAP_W){1'b0}},
                                         min_gap_ff};
         default:              prdata = '0;
      endcase
   end

`ifndef ASSERT_OFF
   // an accepted beat takes the sequencer away from fetch
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while a beat is in progress");

   // a recorded pulse never carries a speed
   a_rec_no_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.pulse_recorded) |-> (rsp.speed_q8 == '0))
      else $error("recorded pulse with non-zero speed");

   // the recorded gap becomes both the latest gap and the newest window entry
   a_latest_in_window: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.act == pgt_pkg::ACT_EDGE) && over_min)
         |=> (window_ff[WINDOW_DEPTH-1] == latest_ff))
      else $error("latest gap and newest window entry differ");

   // idle fill never pushes more than the window holds
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("idle fill count beyond window depth");
`endif

endmodule

`default_nettype wire
